@@ rtl/odp_pkg.sv @@
// Shared types and constants for the originator detection pattern detector.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps
package odp_pkg;

   localparam int GAP_W   = 5;
   localparam int COUNT_W = 3;
   localparam int CHAR_W  = 8;
   localparam int BIT_IDX_W = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CHAR_W-1:0] DC1_EVEN   = 8'h11;
   localparam logic [CHAR_W-1:0] DC1_ODD    = 8'h91;
   localparam logic [CHAR_W-1:0] DC1_TOGGLE = 8'h80;

   localparam logic [BIT_IDX_W-1:0] STOP_BIT_INDEX = 4'd8;
   localparam logic [COUNT_W-1:0]   COUNT_MAX      = 3'd7;

   localparam logic [GAP_W-1:0]   MIN_GAP_RESET  = 5'd8;
   localparam logic [GAP_W-1:0]   MAX_GAP_RESET  = 5'd16;
   localparam logic [COUNT_W-1:0] REQUIRED_RESET = 3'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_GAP  = 2'd0,
      CSR_MAX_GAP  = 2'd1,
      CSR_REQUIRED = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_FEED  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef struct packed {
      logic                 in_char;
      logic [BIT_IDX_W-1:0] bit_index;
      logic [CHAR_W-1:0]    char_shift;
      logic                 have_prev;
      logic [CHAR_W-1:0]    prev_char;
      logic [COUNT_W-1:0]   char_count;
      logic [GAP_W-1:0]     mark_run;
      logic                 found;
   } det_state_type;

endpackage

@@ rtl/odp_if.sv @@
// Request and response channel interfaces of the pattern detector.
// Depends on odp_pkg for field widths.
`timescale 1ns / 1ps
interface odp_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic line_bit;

   modport source (output valid, output cmd, output line_bit, input ready);
   modport sink   (input valid, input cmd, input line_bit, output ready);
endinterface

interface odp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        detected;
   logic [odp_pkg::COUNT_W-1:0] valid_count;

   modport source (output valid, output detected, output valid_count, input ready);
   modport sink   (input valid, input detected, input valid_count, output ready);
endinterface

@@ rtl/odp_pattern_detector.sv @@
// Originator detection pattern detector: frames async DC1 characters from
// line bits and raises a sticky flag. Depends on odp_pkg and odp_if.sv.
//
// Usage:
//   req_chan carries one request per line bit: cmd 0 feeds line_bit
//   (1 mark, 0 space), cmd 1 clears the detector. Each request gives one
//   response on rsp_chan with the detected flag and the count of
//   consecutive valid characters after that request's update.
//   csr_we/csr_index/csr_wdata write min_gap_marks (0), max_gap_marks (1)
//   and required_chars (2); write only while no request is in flight.
//   A request passes through an input register and then a response
//   register, where its response becomes valid on rsp_chan.
//   Throughput: one request per cycle while rsp_chan does not stall; the
//   detector state updates as a request moves from the input register to
//   the response register.
//   When rsp_chan stalls the response register holds, the input register
//   fills, and req_chan.ready drops only when both are full.
//   Synchronous reset empties both registers, clears the detector state and
//   restores the registers to 8, 16 and 4.
`timescale 1ns / 1ps
module odp_pattern_detector (
   input  logic                           clock,
   input  logic                           reset,
   odp_req_if.sink                        req_chan,
   odp_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [odp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [odp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import odp_pkg::*;

   logic [GAP_W-1:0]   min_gap_ff;
   logic [GAP_W-1:0]   max_gap_ff;
   logic [COUNT_W-1:0] required_ff;

   logic          req_valid_ff;
   logic          req_cmd_ff;
   logic          req_bit_ff;
   logic          rsp_valid_ff;
   logic          rsp_detected_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   det_state_type state_ff;
   det_state_type state_in;

   logic          advance;
   logic [GAP_W:0] next_run;
   logic          is_dc1;
   logic          alternates;

   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.detected    = rsp_detected_ff;
   assign rsp_chan.valid_count = rsp_count_ff;

   assign next_run   = {1'b0, state_ff.mark_run} + {{GAP_W{1'b0}}, 1'b1};
   assign is_dc1     = req_bit_ff
                       && (state_ff.char_shift == DC1_EVEN || state_ff.char_shift == DC1_ODD);
   assign alternates = state_ff.char_shift == (state_ff.prev_char ^ DC1_TOGGLE);

   always_comb begin
      state_in = state_ff;
      if (req_cmd_ff == CMD_CLEAR) begin
         state_in = '0;
      end else if (!state_ff.found) begin
         if (state_ff.in_char) begin
            if (state_ff.bit_index < STOP_BIT_INDEX) begin
               state_in.char_shift = state_ff.char_shift
                  | (CHAR_W'(req_bit_ff) << state_ff.bit_index[BIT_IDX_W-2:0]);
               state_in.bit_index  = state_ff.bit_index + 1'b1;
            end else begin
               // end of character, stop bit in hand
               state_in.in_char  = 1'b0;
               state_in.mark_run = '0;
               if (is_dc1) begin
                  state_in.prev_char = state_ff.char_shift;
                  state_in.have_prev = 1'b1;
                  if (!state_ff.have_prev || alternates) begin
                     if (state_ff.char_count < COUNT_MAX) begin
                        state_in.char_count = state_ff.char_count + 1'b1;
                     end
                     if (state_in.char_count >= required_ff) begin
                        state_in.found = 1'b1;
                     end
                  end else begin
                     state_in.char_count = COUNT_W'(1);
                  end
               end else begin
                  state_in.have_prev  = 1'b0;
                  state_in.char_count = '0;
               end
            end
         end else if (!state_ff.have_prev) begin
            if (!req_bit_ff) begin
               state_in.in_char    = 1'b1;
               state_in.bit_index  = '0;
               state_in.char_shift = '0;
            end
         end else if (req_bit_ff) begin
            if (next_run > {1'b0, max_gap_ff}) begin
               state_in.have_prev  = 1'b0;
               state_in.char_count = '0;
               state_in.mark_run   = '0;
            end else begin
               state_in.mark_run = next_run[GAP_W-1:0];
            end
         end else begin
            if (state_ff.mark_run < min_gap_ff || state_ff.mark_run > max_gap_ff) begin
               state_in.have_prev  = 1'b0;
               state_in.char_count = '0;
            end
            state_in.in_char    = 1'b1;
            state_in.bit_index  = '0;
            state_in.char_shift = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff   <= MIN_GAP_RESET;
         max_gap_ff   <= MAX_GAP_RESET;
         required_ff  <= REQUIRED_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_GAP:  min_gap_ff  <= csr_wdata;
               CSR_MAX_GAP:  max_gap_ff  <= csr_wdata;
               CSR_REQUIRED: required_ff <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         req_cmd_ff <= req_chan.cmd;
         req_bit_ff <= req_chan.line_bit;
      end
      if (advance) begin
         rsp_detected_ff <= state_in.found;
         rsp_count_ff    <= state_in.char_count;
      end
   end

endmodule

@@ rtl/odp_checker.sv @@
// Port-level checks for odp_pattern_detector, attached by bind.
// Depends on odp_pkg for widths.
`timescale 1ns / 1ps
module odp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_detected,
   input logic [odp_pkg::COUNT_W-1:0] rsp_valid_count
);
   import odp_pkg::*;

   // a stalled response stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_detected)
      && $stable(rsp_valid_count))
      else $error("response changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a saturated count always meets any required count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_count == COUNT_MAX |-> rsp_detected)
      else $error("full count without detection");

   // detection is raised only on a character boundary, so count is nonzero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_detected |-> rsp_valid_count != '0)
      else $error("detected with zero count");

endmodule

bind odp_pattern_detector odp_checker u_odp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_detected    (rsp_chan.detected),
   .rsp_valid_count (rsp_chan.valid_count)
);

@@ tb/sv/odp_pattern_detector_test.sv @@
// Self-checking test of odp_pattern_detector: drives line bits and clear requests,
// predicts the detected flag and the valid DC1 count, and compares every response.
// Depends on odp_pkg, odp_if.sv and the detector RTL.
`timescale 1ns / 1ps
module odp_pattern_detector_test;
   import odp_pkg::*;

   localparam int PENDING_DEPTH = 1024;

   typedef struct packed {
      logic               detected;
      logic [COUNT_W-1:0] valid_count;
   } flag_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   odp_req_if req_chan ();
   odp_rsp_if rsp_chan ();

   odp_pattern_detector u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   det_state_type      line_st;
   logic [GAP_W-1:0]   cfg_min_gap;
   logic [GAP_W-1:0]   cfg_max_gap;
   logic [COUNT_W-1:0] cfg_required;
   flag_result_type    pending_flags[PENDING_DEPTH];
   int                 pending_head = 0;
   int                 pending_tail = 0;
   int                 error_count = 0;
   int                 phase_requests = 0;
   bit                 req_idle_en = 1'b0;
   bit                 rsp_stall_en = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(2_000_000);
      $display("odp_pattern_detector test failed");
      $finish;
   end

   // ---------------- detector prediction ----------------

   function automatic void close_char(input logic stop_mark);
      logic dc1;
      dc1 = stop_mark && (line_st.char_shift == DC1_EVEN || line_st.char_shift == DC1_ODD);
      line_st.in_char = 1'b0;
      if (dc1 && (!line_st.have_prev ||
                  line_st.char_shift == (line_st.prev_char ^ DC1_TOGGLE))) begin
         line_st.prev_char = line_st.char_shift;
         line_st.have_prev = 1'b1;
         if (line_st.char_count < COUNT_MAX)
            line_st.char_count = line_st.char_count + 1'b1;
         if (line_st.char_count >= cfg_required)
            line_st.found = 1'b1;
      end else if (dc1) begin
         line_st.prev_char  = line_st.char_shift;
         line_st.have_prev  = 1'b1;
         line_st.char_count = COUNT_W'(1);
      end else begin
         line_st.have_prev  = 1'b0;
         line_st.char_count = '0;
      end
      line_st.mark_run = '0;
   endfunction

   function automatic void open_char();
      line_st.in_char    = 1'b1;
      line_st.bit_index  = '0;
      line_st.char_shift = '0;
   endfunction

   function automatic void feed_line_bit(input logic b);
      logic [GAP_W:0] next_run;
      if (line_st.in_char) begin
         if (line_st.bit_index < STOP_BIT_INDEX) begin
            line_st.char_shift = line_st.char_shift | (CHAR_W'(b) << line_st.bit_index);
            line_st.bit_index  = line_st.bit_index + 1'b1;
         end else begin
            close_char(b);
         end
      end else if (!line_st.have_prev) begin
         if (!b)
            open_char();
      end else if (b) begin
         next_run = {1'b0, line_st.mark_run} + 1'b1;
         if (next_run > {1'b0, cfg_max_gap}) begin
            line_st.have_prev  = 1'b0;
            line_st.char_count = '0;
            line_st.mark_run   = '0;
         end else begin
            line_st.mark_run = next_run[GAP_W-1:0];
         end
      end else begin
         if (line_st.mark_run < cfg_min_gap || line_st.mark_run > cfg_max_gap) begin
            line_st.have_prev  = 1'b0;
            line_st.char_count = '0;
         end
         open_char();
      end
   endfunction

   // ---------------- request side ----------------

   task automatic send_request(input cmd_type c, input logic b);
      flag_result_type want;
      if (req_idle_en) begin
         while ($urandom_range(99) < 18) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid    <= 1'b1;
      req_chan.cmd      <= c;
      req_chan.line_bit <= b;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      if (c == CMD_CLEAR)
         line_st = '0;
      else if (!line_st.found)
         feed_line_bit(b);
      want.detected    = line_st.found;
      want.valid_count = line_st.char_count;
      pending_flags[pending_tail % PENDING_DEPTH] = want;
      pending_tail++;
      phase_requests++;
   endtask

   task automatic send_marks(input int n);
      repeat (n) send_request(CMD_FEED, 1'b1);
   endtask

   task automatic send_char(input logic [CHAR_W-1:0] data, input logic stop);
      send_request(CMD_FEED, 1'b0);
      for (int i = 0; i < CHAR_W; i++)
         send_request(CMD_FEED, data[i]);
      send_request(CMD_FEED, stop);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_tail != pending_head)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input int min_gap, input int max_gap, input int required);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_GAP;
      csr_wdata <= CSR_DATA_W'(min_gap);
      @(posedge clock);
      csr_index <= CSR_MAX_GAP;
      csr_wdata <= CSR_DATA_W'(max_gap);
      @(posedge clock);
      csr_index <= CSR_REQUIRED;
      csr_wdata <= CSR_DATA_W'(required & 7);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_min_gap  = GAP_W'(min_gap);
      cfg_max_gap  = GAP_W'(max_gap);
      cfg_required = COUNT_W'(required);
      phase_requests = 0;
   endtask

   // ---------------- response side ----------------

   always @(posedge clock) begin
      flag_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_tail == pending_head) begin
            $display("%0t: unexpected response: expected none, actual detected=%0d count=%0d",
                     $time, rsp_chan.detected, rsp_chan.valid_count);
            error_count++;
         end else begin
            want = pending_flags[pending_head % PENDING_DEPTH];
            pending_head++;
            if (rsp_chan.detected !== want.detected) begin
               $display("%0t: detected mismatch: expected %0d, actual %0d", $time,
                        want.detected, rsp_chan.detected);
               error_count++;
            end
            if (rsp_chan.valid_count !== want.valid_count) begin
               $display("%0t: valid_count mismatch: expected %0d, actual %0d", $time,
                        want.valid_count, rsp_chan.valid_count);
               error_count++;
            end
         end
      end
      rsp_chan.ready <= rsp_stall_en ? ($urandom_range(99) >= 18) : 1'b1;
   end

   // ---------------- tests ----------------

   task automatic test_default_detection();
      // reset values 8/16/4: four alternating DC1s, gaps at both limits
      cfg_min_gap  = MIN_GAP_RESET;
      cfg_max_gap  = MAX_GAP_RESET;
      cfg_required = REQUIRED_RESET;
      send_marks(3);
      send_char(DC1_EVEN, 1'b1);
      send_marks(8);
      send_char(DC1_ODD, 1'b1);
      send_marks(16);
      send_char(DC1_EVEN, 1'b1);
      send_marks(10);
      send_char(DC1_ODD, 1'b1);
      // ignored once detected
      send_request(CMD_FEED, 1'b0);
      send_marks(2);
      send_request(CMD_CLEAR, 1'b1);
      send_request(CMD_FEED, 1'b1);
   endtask

   task automatic test_required_zero();
      set_config(0, 0, 0);
      send_char(DC1_ODD, 1'b1);
      send_request(CMD_CLEAR, 1'b0);
      set_config(0, 0, 2);
      send_char(DC1_EVEN, 1'b1);
      send_char(DC1_ODD, 1'b1);
      send_request(CMD_CLEAR, 1'b1);
   endtask

   task automatic test_gap_and_char_errors();
      set_config(2, 4, 3);
      send_char(DC1_EVEN, 1'b1);
      send_marks(1);
      send_char(DC1_ODD, 1'b1);          // gap too short
      send_marks(5);                      // gap too long
      send_char(DC1_EVEN, 1'b1);
      send_marks(3);
      send_char(DC1_EVEN, 1'b1);          // same DC1 twice
      send_marks(2);
      send_char(DC1_ODD, 1'b0);           // missing stop bit
      send_char(8'h13, 1'b1);             // not a DC1
      send_char(8'hFF, 1'b1);
      send_request(CMD_FEED, 1'b0);
      send_request(CMD_CLEAR, 1'b0);      // clear mid-character
   endtask

   task automatic test_min_above_max();
      set_config(6, 3, 2);
      send_char(DC1_EVEN, 1'b1);
      send_marks(3);
      send_char(DC1_ODD, 1'b1);
      send_marks(3);
      send_char(DC1_EVEN, 1'b1);
      send_request(CMD_CLEAR, 1'b0);
   endtask

   task automatic test_extreme_gaps();
      set_config(31, 31, 2);
      send_char(DC1_ODD, 1'b1);
      send_marks(32);                     // one past the widest gap
      send_char(DC1_ODD, 1'b1);
      send_marks(31);
      send_char(DC1_EVEN, 1'b1);
      send_request(CMD_CLEAR, 1'b1);
   endtask

   task automatic send_dc1_run();
      logic [CHAR_W-1:0] c;
      int n, bad_at, kind;
      n      = (cfg_required == 0) ? 1 : cfg_required + $urandom_range(0, 1);
      bad_at = ($urandom_range(99) < 15) ? $urandom_range(0, n - 1) : -1;
      c      = $urandom_range(1) ? DC1_ODD : DC1_EVEN;
      send_marks($urandom_range(0, 3));
      for (int i = 0; i < n; i++) begin
         if (i > 0)
            send_marks(cfg_min_gap <= cfg_max_gap ?
                       $urandom_range(cfg_min_gap, cfg_max_gap) : $urandom_range(0, 9));
         if (i == bad_at) begin
            kind = $urandom_range(0, 2);
            if (kind == 0)
               send_char(c, 1'b0);
            else if (kind == 1)
               send_char(c ^ DC1_TOGGLE, 1'b1);
            else
               send_char(CHAR_W'($urandom_range(255)), 1'b1);
         end else begin
            send_char(c, 1'b1);
         end
         c = c ^ DC1_TOGGLE;
      end
      send_marks($urandom_range(0, 3));
      if ($urandom_range(99) < 60)
         send_request(CMD_CLEAR, 1'($urandom_range(1)));
   endtask

   task automatic send_noise();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         repeat ($urandom_range(1, 20))
            send_request(CMD_FEED, 1'($urandom_range(1)));
      end else if (pick < 65) begin
         send_char(DC1_EVEN, 1'b1);
         send_marks($urandom_range(0, 1) ? int'(cfg_max_gap) + 1 :
                    $urandom_range(0, cfg_min_gap));
         send_char(DC1_ODD, 1'b1);
      end else if (pick < 80) begin
         send_request(CMD_CLEAR, 1'($urandom_range(1)));
      end else begin
         send_char(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_config($urandom_range(0, 3), $urandom_range(3, 6), $urandom_range(1, 3));
            2: set_config($urandom_range(4, 8), $urandom_range(0, 3), $urandom_range(1, 7));
            3: set_config($urandom_range(0, 2), $urandom_range(2, 5), 0);
            default: set_config($urandom_range(0, 4), $urandom_range(4, 9),
                                $urandom_range(1, 7));
         endcase
         // first phase runs with no idling on either side
         req_idle_en  = (phase != 0);
         rsp_stall_en = (phase != 0);
         while (phase_requests < 20) begin
            if ($urandom_range(99) < 65)
               send_dc1_run();
            else
               send_noise();
            if (phase == 1 && $urandom_range(99) < 10)
               wait_for_results();
         end
      end
   endtask

   initial begin
      req_chan.valid    <= 1'b0;
      req_chan.cmd      <= CMD_FEED;
      req_chan.line_bit <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_MIN_GAP;
      csr_wdata         <= '0;
      line_st = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_detection();
      req_idle_en  = 1'b1;
      rsp_stall_en = 1'b1;
      test_required_zero();
      test_gap_and_char_errors();
      test_min_above_max();
      test_extreme_gaps();
      test_random_traffic();

      wait_for_results();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_tail == pending_head)
         $display("odp_pattern_detector test passed");
      else
         $display("odp_pattern_detector test failed");
      $finish;
   end

endmodule

@@ odp_pattern_detector.f @@
rtl/odp_pkg.sv
rtl/odp_if.sv
rtl/odp_pattern_detector.sv
rtl/odp_checker.sv
tb/sv/odp_pattern_detector_test.sv
